### hw/rtl/vmplt_pkg.sv
// Package for the VM placement load table: field widths, action and
// register codes, sequencer states and saturating load arithmetic.
// Depends on nothing; the top level uses it by scoped names.
package vmplt_pkg;

  localparam int LOAD_W = 16;
  localparam int IDX_W  = 6;
  localparam int ACT_W  = 3;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  localparam logic [ACT_W-1:0] ACT_PLACE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MIGRATE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIT     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_VARCHK  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 3'd4;

  localparam logic CFG_UTIL_LIMIT = 1'b0;
  localparam logic CFG_LOW_LIMIT  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ1,
    ST_READ2,
    ST_WRITE2,
    ST_VAR1,
    ST_VAR2,
    ST_VAR3,
    ST_VAR4
  } state_t;

  function automatic logic [LOAD_W-1:0] sat_add(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] sat_sub(input logic [LOAD_W-1:0] a,
                                                 input logic [LOAD_W-1:0] b);
    return (b > a) ? '0 : a - b;
  endfunction

endpackage

### hw/rtl/vm_placement_load_table_top.sv
// Top level of the VM placement load table: host load memory, guest home
// memory, the action sequencer and the exact variance-change test.
// Depends on vmplt_pkg.
// From accept to the out_valid beat: place, fit check, host query, same-host
// moves and out-of-range hosts pass through READ1 alone; a migrate between
// two hosts runs READ1, READ2, WRITE2; a variance check runs READ1, READ2 and
// VAR1 to VAR4. Busy drops in the beat cycle. The single read port of the host
// load memory sets this order. After reset a clearing pass zeroes host loads.
module vm_placement_load_table_top #(
  parameter int HOST_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_action,
  input  logic [5:0]  in_guest_index,
  input  logic [5:0]  in_host_index,
  input  logic [15:0] in_load,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_valid,
  output logic        out_fits,
  output logic        out_variance_rises,
  output logic [15:0] out_host_total,
  output logic        out_over_limit,
  output logic        out_under_low,
  output logic [5:0]  out_previous_host
);

  localparam int AW    = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
  localparam int LW    = vmplt_pkg::LOAD_W;
  localparam int IW    = vmplt_pkg::IDX_W;
  localparam int SUM_W = LW + AW;
  localparam int Q_W   = SUM_W + 18;
  localparam int CMP_W = 36 + AW;
  localparam logic signed [CMP_W-1:0] N_S = CMP_W'(HOST_COUNT);

  logic [LW-1:0] host_mem [HOST_COUNT];
  logic [IW-1:0] guest_mem [64];
  logic [LW-1:0] host_rd_r;
  logic [IW-1:0] guest_rd_r;

  vmplt_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [LW-1:0]    util_limit_r, util_limit_nxt;
  logic [LW-1:0]    low_limit_r, low_limit_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [2:0]    act_r;
  logic [IW-1:0] guest_r, host_r, old_r;
  logic [LW-1:0] load_r, b_r, b_new_r, da_r, db_r;
  logic          range_ok_r;
  logic [LW:0]   a_sum_r, b_sum_r;
  logic [32:0]   p1_r, p2_r;
  logic signed [16:0]      dd_r;
  logic signed [33:0]      t_r, r_r;
  logic signed [Q_W-1:0]   q_r;
  logic signed [CMP_W-1:0] lhs_r, rhs_r;

  logic          out_fits_r, out_rises_r, out_over_r, out_under_r;
  logic [LW-1:0] out_total_r;
  logic [IW-1:0] out_prev_r;

  logic [AW+IW-1:0] in_host_wide, host_wide, old_wide, rd_old_wide;
  logic [AW-1:0]    in_addr, host_addr, old_addr, rd_old_addr;
  logic             in_ok, accept, same_host;

  logic          mem_we, gh_we, done;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [LW-1:0] mem_wdata, mem_wold;

  logic          res_ok, res_fits, res_rises;
  logic [LW-1:0] res_total;
  logic [IW-1:0] res_prev;

  assign in_host_wide = {{AW{1'b0}}, in_host_index};
  assign host_wide    = {{AW{1'b0}}, host_r};
  assign old_wide     = {{AW{1'b0}}, old_r};
  assign rd_old_wide  = {{AW{1'b0}}, guest_rd_r};
  assign in_addr      = in_host_wide[AW-1:0];
  assign host_addr    = host_wide[AW-1:0];
  assign old_addr     = old_wide[AW-1:0];
  assign rd_old_addr  = rd_old_wide[AW-1:0];
  assign in_ok        = in_host_wide < (AW+IW)'(HOST_COUNT);
  assign same_host    = guest_rd_r == host_r;

  assign busy   = state_r != vmplt_pkg::ST_IDLE;
  assign accept = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      vmplt_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(HOST_COUNT - 1)) begin
          state_nxt = vmplt_pkg::ST_IDLE;
        end
      end
      vmplt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = vmplt_pkg::ST_READ1;
        end
      end
      vmplt_pkg::ST_READ1: begin
        if (range_ok_r && !same_host &&
            (act_r == vmplt_pkg::ACT_MIGRATE || act_r == vmplt_pkg::ACT_VARCHK)) begin
          state_nxt = vmplt_pkg::ST_READ2;
        end else begin
          state_nxt = vmplt_pkg::ST_IDLE;
        end
      end
      vmplt_pkg::ST_READ2: begin
        state_nxt = (act_r == vmplt_pkg::ACT_MIGRATE) ? vmplt_pkg::ST_WRITE2
                                                      : vmplt_pkg::ST_VAR1;
      end
      vmplt_pkg::ST_WRITE2: state_nxt = vmplt_pkg::ST_IDLE;
      vmplt_pkg::ST_VAR1:   state_nxt = vmplt_pkg::ST_VAR2;
      vmplt_pkg::ST_VAR2:   state_nxt = vmplt_pkg::ST_VAR3;
      vmplt_pkg::ST_VAR3:   state_nxt = vmplt_pkg::ST_VAR4;
      vmplt_pkg::ST_VAR4:   state_nxt = vmplt_pkg::ST_IDLE;
      default:              state_nxt = vmplt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    gh_we     = 1'b0;
    mem_waddr = host_addr;
    mem_wdata = b_new_r;
    mem_wold  = host_rd_r;
    mem_raddr = (state_r == vmplt_pkg::ST_READ1) ? rd_old_addr : in_addr;
    done      = 1'b0;
    res_ok    = range_ok_r;
    res_fits  = 1'b0;
    res_rises = 1'b0;
    res_total = host_rd_r;
    res_prev  = '0;
    case (state_r)
      vmplt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      vmplt_pkg::ST_READ1: begin
        done = 1'b1;
        case (act_r)
          vmplt_pkg::ACT_PLACE: begin
            mem_we    = range_ok_r;
            gh_we     = range_ok_r;
            mem_wdata = vmplt_pkg::sat_add(host_rd_r, load_r);
            res_total = mem_wdata;
          end
          vmplt_pkg::ACT_MIGRATE: begin
            res_prev = guest_rd_r;
            if (same_host) begin
              mem_we    = range_ok_r;
              gh_we     = range_ok_r;
              mem_wdata = vmplt_pkg::sat_add(vmplt_pkg::sat_sub(host_rd_r, load_r), load_r);
              res_total = mem_wdata;
            end else begin
              done = !range_ok_r;
            end
          end
          vmplt_pkg::ACT_FIT: begin
            res_fits = ({1'b0, host_rd_r} + {1'b0, load_r}) <= {1'b0, util_limit_r};
          end
          vmplt_pkg::ACT_VARCHK: begin
            res_prev = guest_rd_r;
            done     = same_host || !range_ok_r;
          end
          default: begin
            res_total = host_rd_r;
          end
        endcase
      end
      vmplt_pkg::ST_READ2: begin
        if (act_r == vmplt_pkg::ACT_MIGRATE) begin
          mem_we    = 1'b1;
          gh_we     = 1'b1;
          mem_waddr = old_addr;
          mem_wdata = vmplt_pkg::sat_sub(host_rd_r, load_r);
        end
      end
      vmplt_pkg::ST_WRITE2: begin
        mem_we    = 1'b1;
        mem_wold  = b_r;
        done      = 1'b1;
        res_total = b_new_r;
        res_prev  = old_r;
      end
      vmplt_pkg::ST_VAR4: begin
        done      = 1'b1;
        res_total = b_r;
        res_prev  = old_r;
        res_rises = lhs_r > rhs_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    sum_nxt = sum_r;
    if (mem_we && state_r != vmplt_pkg::ST_CLEAR) begin
      sum_nxt = sum_r + SUM_W'(mem_wdata) - SUM_W'(mem_wold);
    end
    util_limit_nxt = util_limit_r;
    low_limit_nxt  = low_limit_r;
    if (cfg_we) begin
      case (cfg_index)
        vmplt_pkg::CFG_UTIL_LIMIT: util_limit_nxt = cfg_wdata;
        vmplt_pkg::CFG_LOW_LIMIT:  low_limit_nxt  = cfg_wdata;
        default:                   util_limit_nxt = util_limit_r;
      endcase
    end
    out_valid_nxt = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vmplt_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      sum_r        <= '0;
      util_limit_r <= 16'd3277;
      low_limit_r  <= 16'd1229;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      sum_r        <= sum_nxt;
      util_limit_r <= util_limit_nxt;
      low_limit_r  <= low_limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      host_mem[mem_waddr] <= mem_wdata;
    end
    host_rd_r <= host_mem[mem_raddr];
    if (gh_we) begin
      guest_mem[guest_r] <= host_r;
    end
    guest_rd_r <= guest_mem[in_guest_index];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= in_action;
      guest_r    <= in_guest_index;
      host_r     <= in_host_index;
      load_r     <= in_load;
      range_ok_r <= in_ok;
    end
    if (state_r == vmplt_pkg::ST_READ1) begin
      b_r   <= host_rd_r;
      old_r <= guest_rd_r;
    end
    if (state_r == vmplt_pkg::ST_READ2) begin
      b_new_r <= vmplt_pkg::sat_add(b_r, load_r);
      da_r    <= host_rd_r - vmplt_pkg::sat_sub(host_rd_r, load_r);
      db_r    <= vmplt_pkg::sat_add(b_r, load_r) - b_r;
      a_sum_r <= {1'b0, host_rd_r} + {1'b0, vmplt_pkg::sat_sub(host_rd_r, load_r)};
      b_sum_r <= {1'b0, b_r} + {1'b0, vmplt_pkg::sat_add(b_r, load_r)};
    end
    if (state_r == vmplt_pkg::ST_VAR1) begin
      p1_r <= 33'(db_r) * 33'(b_sum_r);
      p2_r <= 33'(da_r) * 33'(a_sum_r);
      dd_r <= $signed({1'b0, db_r}) - $signed({1'b0, da_r});
    end
    if (state_r == vmplt_pkg::ST_VAR2) begin
      t_r <= $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
      q_r <= $signed({1'b0, sum_r}) * dd_r;
      r_r <= dd_r * dd_r;
    end
    if (state_r == vmplt_pkg::ST_VAR3) begin
      lhs_r <= CMP_W'(t_r) * N_S;
      rhs_r <= (CMP_W'(q_r) <<< 1) + CMP_W'(r_r);
    end
    if (done) begin
      out_fits_r  <= res_ok && res_fits;
      out_rises_r <= res_ok && res_rises;
      out_total_r <= res_ok ? res_total : '0;
      out_over_r  <= res_ok && (res_total > util_limit_r);
      out_under_r <= res_ok && (res_total < low_limit_r);
      out_prev_r  <= res_ok ? res_prev : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_fits           = out_fits_r;
  assign out_variance_rises = out_rises_r;
  assign out_host_total     = out_total_r;
  assign out_over_limit     = out_over_r;
  assign out_under_low      = out_under_r;
  assign out_previous_host  = out_prev_r;

endmodule

### hw/rtl/vmplt_checker.sv
// Port-level checker for the VM placement load table and its bind to the
// top level. Depends only on the top level's port names.
module vmplt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_fits,
  input logic out_variance_rises
);

  a_reset_clears : assert property (@(posedge clk) !rst_n |=> busy)
    else $error("Block is not busy with the clearing pass after reset.");

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("An accepted item did not make the block busy.");

  a_beat_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("A result beat appeared while the block was still busy.");

  a_beat_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Two result beats came in consecutive cycles.");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_fits && out_variance_rises))
    else $error("A result beat carried both the fit and the variance flag.");

endmodule

bind vm_placement_load_table_top vmplt_checker u_vmplt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_fits           (out_fits),
  .out_variance_rises (out_variance_rises)
);

### verif/vm_placement_load_table_top_tb.sv
// Testbench for vm_placement_load_table_top: directed and random actions are checked
// beat by beat against an in-bench predictor of the host load and guest home tables.
// Depends on vmplt_pkg and the top level RTL only.
module vm_placement_load_table_top_tb;

  localparam int LOAD_W = vmplt_pkg::LOAD_W;
  localparam int IDX_W  = vmplt_pkg::IDX_W;
  localparam int ACT_W  = vmplt_pkg::ACT_W;

  localparam int HOSTS = 64;
  localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_C = 3'd7;

  typedef struct packed {
    logic             fits;
    logic             rises;
    logic [LOAD_W-1:0] total;
    logic             over;
    logic             under;
    logic [IDX_W-1:0] prev;
  } verdict_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ACT_W-1:0]  in_action = '0;
  logic [IDX_W-1:0]  in_guest_index = '0;
  logic [IDX_W-1:0]  in_host_index = '0;
  logic [LOAD_W-1:0] in_load = '0;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [LOAD_W-1:0] cfg_wdata = '0;
  logic              out_valid;
  logic              out_fits;
  logic              out_variance_rises;
  logic [LOAD_W-1:0] out_host_total;
  logic              out_over_limit;
  logic              out_under_low;
  logic [IDX_W-1:0]  out_previous_host;

  logic [LOAD_W-1:0] host_sum [HOSTS];
  logic [IDX_W-1:0]  guest_host [64];
  logic [LOAD_W-1:0] guest_load [64];
  bit                guest_placed [64];
  logic [LOAD_W-1:0] util_lim_m = 16'd3277;
  logic [LOAD_W-1:0] low_lim_m = 16'd1229;
  verdict_t          pending_results [$];
  verdict_t          want;
  int                failures = 0;
  bit                no_gaps = 1'b0;

  vm_placement_load_table_top #(.HOST_COUNT(HOSTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_guest_index(in_guest_index),
    .in_host_index(in_host_index), .in_load(in_load),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_fits(out_fits),
    .out_variance_rises(out_variance_rises), .out_host_total(out_host_total),
    .out_over_limit(out_over_limit), .out_under_low(out_under_low),
    .out_previous_host(out_previous_host)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < HOSTS; i++) host_sum[i] = '0;
    for (int i = 0; i < 64; i++) begin
      guest_host[i] = '0;
      guest_load[i] = '0;
      guest_placed[i] = 1'b0;
    end
  end

  function automatic logic [LOAD_W-1:0] add_clamped(input logic [LOAD_W-1:0] a,
                                                    input logic [LOAD_W-1:0] b);
    logic [LOAD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 17'd65535) return 16'hFFFF;
    return s[LOAD_W-1:0];
  endfunction

  function automatic logic [LOAD_W-1:0] sub_clamped(input logic [LOAD_W-1:0] a,
                                                    input logic [LOAD_W-1:0] b);
    if (b >= a) return '0;
    return a - b;
  endfunction

  // N * sum(x^2) - (sum x)^2 over the host totals, with up to two entries replaced.
  function automatic longint unsigned spread_with(input int ha, input logic [LOAD_W-1:0] va,
                                                  input int hb, input logic [LOAD_W-1:0] vb);
    longint unsigned s1;
    longint unsigned s2;
    longint unsigned x;
    s1 = 0;
    s2 = 0;
    for (int i = 0; i < HOSTS; i++) begin
      x = (i == hb) ? vb : (i == ha) ? va : host_sum[i];
      s1 += x;
      s2 += x * x;
    end
    return 64'(HOSTS) * s2 - s1 * s1;
  endfunction

  function automatic verdict_t apply_action(input logic [ACT_W-1:0] act,
                                            input logic [IDX_W-1:0] g,
                                            input logic [IDX_W-1:0] h,
                                            input logic [LOAD_W-1:0] ld);
    verdict_t r;
    logic [IDX_W-1:0] home;
    r = '0;
    home = guest_host[g];
    case (act)
      vmplt_pkg::ACT_PLACE: begin
        guest_host[g] = h;
        host_sum[h] = add_clamped(host_sum[h], ld);
      end
      vmplt_pkg::ACT_MIGRATE: begin
        r.prev = home;
        host_sum[home] = sub_clamped(host_sum[home], ld);
        host_sum[h] = add_clamped(host_sum[h], ld);
        guest_host[g] = h;
      end
      vmplt_pkg::ACT_FIT: begin
        r.fits = ({1'b0, host_sum[h]} + {1'b0, ld}) <= {1'b0, util_lim_m};
      end
      vmplt_pkg::ACT_VARCHK: begin
        r.prev = home;
        if (home != h) begin
          r.rises = spread_with(home, sub_clamped(host_sum[home], ld),
                                h, add_clamped(host_sum[h], ld))
                    > spread_with(0, host_sum[0], 0, host_sum[0]);
        end
      end
      default: ;
    endcase
    r.total = host_sum[h];
    r.over = r.total > util_lim_m;
    r.under = r.total < low_lim_m;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected, host_total %0d", out_host_total);
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("fits", want.fits, out_fits);
        check_field("variance_rises", want.rises, out_variance_rises);
        check_field("host_total", want.total, out_host_total);
        check_field("over_limit", want.over, out_over_limit);
        check_field("under_low", want.under, out_under_low);
        check_field("previous_host", want.prev, out_previous_host);
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [IDX_W-1:0] g,
                           input logic [IDX_W-1:0] h, input logic [LOAD_W-1:0] ld);
    @(posedge clk);
    while (!no_gaps && $urandom_range(99) < 19) @(posedge clk);
    start <= 1'b1;
    in_action <= act;
    in_guest_index <= g;
    in_host_index <= h;
    in_load <= ld;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results = {pending_results, apply_action(act, g, h, ld)};
    if (act == vmplt_pkg::ACT_PLACE) begin
      guest_placed[g] = 1'b1;
      guest_load[g] = ld;
    end
    start <= 1'b0;
  endtask

  task automatic write_limits(input logic [LOAD_W-1:0] util, input logic [LOAD_W-1:0] low);
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= vmplt_pkg::CFG_UTIL_LIMIT;
    cfg_wdata <= util;
    @(posedge clk);
    util_lim_m = util;
    cfg_index <= vmplt_pkg::CFG_LOW_LIMIT;
    cfg_wdata <= low;
    @(posedge clk);
    low_lim_m = low;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LOAD_W-1:0] pick_load();
    int r;
    r = $urandom_range(99);
    if (r < 50) return LOAD_W'($urandom_range(4095));
    if (r < 75) return LOAD_W'($urandom_range(16383));
    if (r < 90) return LOAD_W'($urandom);
    return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
  endfunction

  task automatic test_place_and_query();
    send_item(vmplt_pkg::ACT_PLACE, 6'd0, 6'd0, 16'd0);
    send_item(vmplt_pkg::ACT_PLACE, 6'd63, 6'd63, 16'hFFFF);
    send_item(vmplt_pkg::ACT_PLACE, 6'd1, 6'd63, 16'd1);
    send_item(vmplt_pkg::ACT_PLACE, 6'd2, 6'd5, 16'd4096);
    send_item(vmplt_pkg::ACT_QUERY, 6'd0, 6'd63, 16'hFFFF);
    send_item(vmplt_pkg::ACT_QUERY, 6'd63, 6'd0, 16'd0);
  endtask

  task automatic test_migrate();
    send_item(vmplt_pkg::ACT_MIGRATE, 6'd63, 6'd0, 16'hFFFF);
    send_item(vmplt_pkg::ACT_MIGRATE, 6'd2, 6'd5, 16'd4096);
    send_item(vmplt_pkg::ACT_MIGRATE, 6'd1, 6'd7, 16'd1);
  endtask

  task automatic test_fit();
    send_item(vmplt_pkg::ACT_FIT, 6'd0, 6'd5, 16'd0);
    send_item(vmplt_pkg::ACT_FIT, 6'd0, 6'd0, 16'hFFFF);
    send_item(vmplt_pkg::ACT_FIT, 6'd0, 6'd7, util_lim_m - host_sum[7]);
    send_item(vmplt_pkg::ACT_FIT, 6'd0, 6'd7, util_lim_m - host_sum[7] + 16'd1);
  endtask

  task automatic test_variance();
    send_item(vmplt_pkg::ACT_VARCHK, 6'd2, 6'd5, 16'd4096);
    send_item(vmplt_pkg::ACT_VARCHK, 6'd2, 6'd9, 16'd4096);
    send_item(vmplt_pkg::ACT_VARCHK, 6'd2, 6'd7, 16'd4096);
    send_item(vmplt_pkg::ACT_VARCHK, 6'd0, 6'd7, 16'hFFFF);
  endtask

  task automatic test_reserved_actions();
    send_item(ACT_RSVD_A, 6'd0, 6'd0, 16'hFFFF);
    send_item(ACT_RSVD_B, 6'd1, 6'd7, 16'h5A5A);
    send_item(ACT_RSVD_C, 6'd63, 6'd63, 16'hA5A5);
  endtask

  task automatic test_random_mix(input int count, input logic [LOAD_W-1:0] util,
                                 input logic [LOAD_W-1:0] low, input bit steady);
    logic [ACT_W-1:0]  act;
    logic [IDX_W-1:0]  g;
    logic [IDX_W-1:0]  h;
    logic [LOAD_W-1:0] ld;
    int                r;
    write_limits(util, low);
    no_gaps = steady;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 20) act = vmplt_pkg::ACT_PLACE;
      else if (r < 50) act = vmplt_pkg::ACT_MIGRATE;
      else if (r < 65) act = vmplt_pkg::ACT_FIT;
      else if (r < 85) act = vmplt_pkg::ACT_VARCHK;
      else if (r < 95) act = vmplt_pkg::ACT_QUERY;
      else act = ACT_W'($urandom_range(7, 5));
      g = IDX_W'($urandom);
      if (!guest_placed[g]) act = vmplt_pkg::ACT_PLACE;
      h = ($urandom_range(9) == 0) ? guest_host[g] : IDX_W'($urandom);
      ld = pick_load();
      if ((act == vmplt_pkg::ACT_MIGRATE || act == vmplt_pkg::ACT_VARCHK) &&
          $urandom_range(9) < 7)
        ld = guest_load[g];
      if (act == vmplt_pkg::ACT_FIT && $urandom_range(9) == 0 && util_lim_m >= host_sum[h])
        ld = util_lim_m - host_sum[h];
      send_item(act, g, h, ld);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_place_and_query();
    test_migrate();
    test_fit();
    test_variance();
    test_reserved_actions();
    test_random_mix(100, 16'd3277, 16'd1229, 1'b0);
    test_random_mix(100, 16'd0, 16'hFFFF, 1'b0);
    test_random_mix(100, 16'hFFFF, 16'd0, 1'b1);
    test_random_mix(100, LOAD_W'($urandom), LOAD_W'($urandom), 1'b0);
    test_random_mix(100, LOAD_W'($urandom_range(8192)), LOAD_W'($urandom_range(4096)), 1'b0);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
